@@ design/mgsa_pkg.sv @@
// ----------------------------------------------------------------------------
// mgsa_pkg
// Shared types and constants of the max-gap slot allocator.
// ----------------------------------------------------------------------------
package mgsa_pkg;

    localparam int MAX_SEATS_DEF  = 1024;
    localparam int SLOT_W         = 10;
    localparam int SEATS_W        = 11;
    localparam int SEATS_RESET    = 1024;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    // Operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [1:0] STATUS_RELEASED  = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_HELD  = 2'd3;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] chosen_slot;
        logic [1:0]        status;
    } t_out_item;

    // Kind of gap handed to the gap unit
    typedef enum logic [1:0] {
        GAP_LEFT,
        GAP_INTERIOR,
        GAP_RIGHT
    } t_gap_mode;

endpackage

@@ design/max_gap_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// max_gap_slot_allocator_unit
// Seat allocator over a row of slots: allocate at the widest gap, release.
// ----------------------------------------------------------------------------
//  channel   | valid / stall            | payload
//  ----------+--------------------------+-----------------------------------
//  request   | i_in_valid / o_in_stall  | i_in_data  (op, slot_index)
//  result    | o_out_valid / i_out_stall| o_out_data (chosen_slot, status)
//  config    | APB psel/penable/pwrite  | reg 0 num_seats at byte 0
//
//  After reset a clearing pass writes every map entry free, with o_in_stall
//  high (config writes are taken meanwhile).
//  Allocate: a one-slot-per-cycle scan of the occupancy map through its
//  single read port and the shared gap unit, then the right edge gap.
//  Release: map read, check, write back.
//  One item is in flight at a time; a result waiting on i_out_stall holds the
//  finishing step until the output register frees up.
// ----------------------------------------------------------------------------
module max_gap_slot_allocator_unit #(
    parameter int MAX_SEATS = mgsa_pkg::MAX_SEATS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  mgsa_pkg::t_in_item                   i_in_data,
    // Result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output mgsa_pkg::t_out_item                  o_out_data,
    // Config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mgsa_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mgsa_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mgsa_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int SW = $clog2(MAX_SEATS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RIGHT,
        ST_ALLOC_FIN,
        ST_REL_RD,
        ST_REL_CHK
    } t_state;

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    logic [mgsa_pkg::SEATS_W-1:0] r_num_seats;
    logic                         cfg_hit;

    // Word-aligned decode: paddr[2] selects beyond the register list
    assign cfg_hit = !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? mgsa_pkg::APB_DATA_W'(r_num_seats) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_seats <= mgsa_pkg::SEATS_W'(mgsa_pkg::SEATS_RESET);
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_num_seats <= pwdata[mgsa_pkg::SEATS_W-1:0];
        end
    end

    // Last usable slot: zero count acts as one slot, large counts saturate
    logic [SW-1:0] last_slot;
    always_comb begin
        if (r_num_seats == '0) begin
            last_slot = '0;
        end else if (32'(r_num_seats) > 32'(MAX_SEATS)) begin
            last_slot = SW'(MAX_SEATS - 1);
        end else begin
            last_slot = SW'(32'(r_num_seats) - 32'd1);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_state              r_state,     n_state;
    logic [SW-1:0]       r_addr,      n_addr;
    logic [SW-1:0]       r_last,      n_last;
    logic [SW-1:0]       r_rd_idx,    n_rd_idx;
    logic                r_rd_vld,    n_rd_vld;
    logic                r_seen,      n_seen;
    logic [SW-1:0]       r_prev,      n_prev;
    logic [SW-1:0]       r_best_dist, n_best_dist;
    logic [SW-1:0]       r_best_slot, n_best_slot;
    logic [SW-1:0]       r_rel_addr,  n_rel_addr;
    logic [mgsa_pkg::SLOT_W-1:0] r_rel_idx, n_rel_idx;
    logic                r_rel_ok,    n_rel_ok;
    logic                r_out_valid, n_out_valid;
    mgsa_pkg::t_out_item r_out_data,  n_out_data;

    // Memory port
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [SW-1:0] mem_raddr;
    logic          mem_rdata;

    mgsa_occ_mem #(
        .DEPTH  (MAX_SEATS),
        .ADDR_W (SW)
    ) u_occ_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared gap unit: scan steps use the occupied slot just read, the final
    // step evaluates the right edge gap
    mgsa_pkg::t_gap_mode gap_mode;
    logic [SW-1:0]       gap_pos;
    logic [SW-1:0]       gap_prev;
    logic [SW-1:0]       gap_dist;
    logic [SW-1:0]       gap_slot;

    always_comb begin
        if (r_state == ST_RIGHT) begin
            gap_mode = mgsa_pkg::GAP_RIGHT;
            gap_pos  = r_last;
        end else begin
            gap_mode = r_seen ? mgsa_pkg::GAP_INTERIOR : mgsa_pkg::GAP_LEFT;
            gap_pos  = r_rd_idx;
        end
        gap_prev = r_seen ? r_prev : '0;
    end

    mgsa_gap_unit #(
        .SW (SW)
    ) u_gap_unit (
        .i_mode      (gap_mode),
        .i_pos       (gap_pos),
        .i_prev      (gap_prev),
        .i_best_dist (r_best_dist),
        .i_best_slot (r_best_slot),
        .o_best_dist (gap_dist),
        .o_best_slot (gap_slot)
    );

    logic out_free;
    logic hit;

    // Output register may be refilled when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // Occupied slot arriving from the scan read
    assign hit      = r_rd_vld && mem_rdata;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        n_rd_idx    = r_addr;
        n_rd_vld    = 1'b0;
        n_seen      = r_seen;
        n_prev      = r_prev;
        n_best_dist = r_best_dist;
        n_best_slot = r_best_slot;
        n_rel_addr  = r_rel_addr;
        n_rel_idx   = r_rel_idx;
        n_rel_ok    = r_rel_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = 1'b0;
        mem_raddr   = r_addr;

        // Fold an occupied slot from the scan into the running best
        if (hit) begin
            n_best_dist = gap_dist;
            n_best_slot = gap_slot;
            n_prev      = r_rd_idx;
            n_seen      = 1'b1;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == SW'(MAX_SEATS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.op == mgsa_pkg::OP_ALLOC) begin
                        n_state     = ST_SCAN;
                        n_addr      = '0;
                        n_last      = last_slot;
                        n_seen      = 1'b0;
                        n_prev      = '0;
                        n_best_dist = '0;
                        n_best_slot = '0;
                    end else begin
                        n_state    = ST_REL_RD;
                        n_rel_idx  = i_in_data.slot_index;
                        n_rel_addr = SW'(i_in_data.slot_index);
                        n_rel_ok   = 32'(i_in_data.slot_index) < 32'(MAX_SEATS);
                    end
                end
            end
            ST_SCAN: begin
                // Issue one map read a cycle; data comes back next cycle
                n_rd_vld = 1'b1;
                if (r_addr == r_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_RIGHT;
            end
            ST_RIGHT: begin
                if (r_seen) begin
                    n_best_dist = gap_dist;
                    n_best_slot = gap_slot;
                end
                n_state = ST_ALLOC_FIN;
            end
            ST_ALLOC_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (!r_seen) begin
                        // Empty row takes slot 0
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = 1'b1;
                        n_out_data = '{chosen_slot: '0,
                                       status: mgsa_pkg::STATUS_ALLOCATED};
                    end else if (r_best_dist == '0) begin
                        n_out_data = '{chosen_slot: '0,
                                       status: mgsa_pkg::STATUS_FULL};
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = r_best_slot;
                        mem_wdata  = 1'b1;
                        n_out_data = '{chosen_slot: mgsa_pkg::SLOT_W'(r_best_slot),
                                       status: mgsa_pkg::STATUS_ALLOCATED};
                    end
                end
            end
            ST_REL_RD: begin
                mem_raddr = r_rel_addr;
                n_state   = ST_REL_CHK;
            end
            ST_REL_CHK: begin
                mem_raddr = r_rel_addr;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_rel_ok && mem_rdata) begin
                        mem_we     = 1'b1;
                        mem_waddr  = r_rel_addr;
                        mem_wdata  = 1'b0;
                        n_out_data = '{chosen_slot: r_rel_idx,
                                       status: mgsa_pkg::STATUS_RELEASED};
                    end else begin
                        n_out_data = '{chosen_slot: r_rel_idx,
                                       status: mgsa_pkg::STATUS_NOT_HELD};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_last      <= n_last;
        r_rd_idx    <= n_rd_idx;
        r_seen      <= n_seen;
        r_prev      <= n_prev;
        r_best_dist <= n_best_dist;
        r_best_slot <= n_best_slot;
        r_rel_addr  <= n_rel_addr;
        r_rel_idx   <= n_rel_idx;
        r_rel_ok    <= n_rel_ok;
        r_out_data  <= n_out_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ design/mgsa_occ_mem.sv @@
// ----------------------------------------------------------------------------
// mgsa_occ_mem
// Occupancy map: one bit per slot, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module mgsa_occ_mem #(
    parameter int DEPTH  = mgsa_pkg::MAX_SEATS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mgsa_gap_unit.sv @@
// ----------------------------------------------------------------------------
// mgsa_gap_unit
// Gap evaluator: distance and offered slot of one gap, kept if it beats best.
// ----------------------------------------------------------------------------
module mgsa_gap_unit #(
    parameter int SW = 10
) (
    input  mgsa_pkg::t_gap_mode i_mode,
    input  logic [SW-1:0]       i_pos,
    input  logic [SW-1:0]       i_prev,
    input  logic [SW-1:0]       i_best_dist,
    input  logic [SW-1:0]       i_best_slot,
    output logic [SW-1:0]       o_best_dist,
    output logic [SW-1:0]       o_best_slot
);

    logic [SW-1:0] diff;
    logic [SW:0]   sum;
    logic [SW-1:0] gap_len;
    logic [SW-1:0] cand;

    assign diff = i_pos - i_prev;
    assign sum  = {1'b0, i_pos} + {1'b0, i_prev};

    always_comb begin
        unique case (i_mode)
            mgsa_pkg::GAP_LEFT: begin
                gap_len = diff;
                cand    = '0;
            end
            mgsa_pkg::GAP_INTERIOR: begin
                gap_len = diff >> 1;
                cand    = sum[SW:1];
            end
            default: begin
                gap_len = diff;
                cand    = i_pos;
            end
        endcase
    end

    // Keep the earlier gap on ties
    assign o_best_dist = (gap_len > i_best_dist) ? gap_len : i_best_dist;
    assign o_best_slot = (gap_len > i_best_dist) ? cand : i_best_slot;

endmodule
